// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/sgs_pkg.sv =====
// Shared types and constants of the Savitzky-Golay smoother
package sgs_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int COEF_WIDTH       = 18;
    localparam int COEF_COUNT       = 8;
    localparam int COEF_IDX_WIDTH   = $clog2(COEF_COUNT);
    localparam int FRAC_BITS        = 16;
    localparam int MAX_HALF_DEFAULT = 7;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;

    // register indexes
    localparam logic [COEF_IDX_WIDTH-1:0] COEF_CENTER_IDX = COEF_IDX_WIDTH'(0);

    localparam coef_t COEF_CENTER_RESET = COEF_WIDTH'(65536);
    localparam coef_t COEF_DIST_RESET   = COEF_WIDTH'(0);

    typedef struct packed {
        sample_t sample;
        logic    last_sample;
    } sgs_in_t;

    typedef struct packed {
        sample_t filtered;
        logic    end_of_record;
    } sgs_out_t;

endpackage

// ===== sv/sgs_mac.sv =====
// Symmetric weighted sum over the sample window, rounded and saturated
module sgs_mac
    import sgs_pkg::*;
#(
    parameter int MAX_HALF = MAX_HALF_DEFAULT
) (
    input  sample_t hist [2*MAX_HALF+1],
    input  coef_t   coef [COEF_COUNT],
    output sample_t filtered
);

    localparam int PAIR_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = PAIR_W + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_HALF + 1);
    localparam int Q_W    = ACC_W - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (FRAC_BITS - 1));

    logic signed [PROD_W-1:0] prod [MAX_HALF+1];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [Q_W-1:0]    q;
    logic                     in_range;

    // pre-add the two samples at equal distance, then one multiply per distance
    for (genvar d = 0; d <= MAX_HALF; d++)
    begin : g_tap
        logic signed [PAIR_W-1:0] pair;
        if (d == 0)
        begin : g_center
            assign pair = PAIR_W'(hist[MAX_HALF]);
        end
        else
        begin : g_side
            assign pair = PAIR_W'(hist[MAX_HALF-d]) + PAIR_W'(hist[MAX_HALF+d]);
        end
        assign prod[d] = pair * coef[d];
    end

    always_comb
    begin
        acc = '0;
        for (int d = 0; d <= MAX_HALF; d++)
        begin
            acc = acc + ACC_W'(prod[d]);
        end
    end

    // dropping the fraction bits floors, so the bias gives round half up
    assign rounded  = acc + ROUND_BIAS;
    assign q        = rounded[ACC_W-1:FRAC_BITS];
    assign in_range = (&q[Q_W-1:SAMPLE_WIDTH-1]) || !(|q[Q_W-1:SAMPLE_WIDTH-1]);

    always_comb
    begin
        if (in_range)
        begin
            filtered = q[SAMPLE_WIDTH-1:0];
        end
        else if (q[Q_W-1])
        begin
            filtered = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            filtered = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

endmodule

// ===== sv/savitzky_golay_smoother.sv =====
// Savitzky-Golay smoothing filter, top level
//
// Usage:
//   Samples come in on in_data (sample, last_sample) with in_valid/in_stall;
//   smoothed samples leave on out_data (filtered, end_of_record) with
//   out_valid/out_stall. A transfer happens when valid is high and stall low.
//   Coefficients are written through cfg_we/cfg_index/cfg_data; the user must
//   write them only while idle, as the block does not enforce it. The output
//   for sample i appears once sample i+MAX_HALF has been taken. When a sample
//   flagged last_sample is taken, the block stops taking input while it
//   replicates the final sample and drains the pending outputs; the last of
//   them carries end_of_record. From the transfer that completes a window,
//   the window is registered and the weighted sum is then registered into the
//   output register. One sample per cycle is sustained inside a record while
//   out_stall stays low; a record ends with the drain. The history window is
//   a shift register; the sum uses one multiplier per distance and a chain of
//   adders, all between the window and output registers. Reset clears the
//   record state and out_valid, and returns coefficients to center 1.0,
//   others 0. A stalled receiver holds the output register; one more result
//   can wait in the window stage before input is stalled.
module savitzky_golay_smoother
    import sgs_pkg::*;
#(
    parameter int MAX_HALF = MAX_HALF_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  sgs_in_t                   in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output sgs_out_t                  out_data,
    input  logic                      cfg_we,
    input  logic [COEF_IDX_WIDTH-1:0] cfg_index,
    input  coef_t                     cfg_data
);

    localparam int WIN   = 2 * MAX_HALF + 1;
    localparam int CNT_W = $clog2(MAX_HALF + 2);
    localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(MAX_HALF);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_HALF + 1);

    coef_t            coef_reg [COEF_COUNT];
    sample_t          hist_reg [WIN];
    sample_t          hist_next [WIN];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] drain_step_reg, drain_step_next;
    logic [CNT_W-1:0] drain_thr_reg, drain_thr_next;
    logic             calc_valid_reg, calc_valid_next;
    logic             calc_eor_reg, calc_eor_next;
    logic             out_valid_reg, out_valid_next;
    sgs_out_t         out_data_reg, out_data_next;

    logic             out_free;
    logic             calc_free;
    logic             draining;
    logic             in_fire;
    logic             drain_fire;
    logic             fill;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] tail_cnt;
    sample_t          shift_in;
    sample_t          filtered;

    assign out_free   = !out_valid_reg || !out_stall;
    assign calc_free  = !calc_valid_reg || out_free;
    assign draining   = (drain_step_reg != '0);
    assign in_stall   = draining || !calc_free;
    assign in_fire    = in_valid && !in_stall;
    assign drain_fire = draining && calc_free;

    assign count_inc = (count_reg <= HALF_CNT) ? count_reg + CNT_W'(1) : count_reg;
    assign tail_cnt  = (count_inc > HALF_CNT) ? HALF_CNT : count_inc;

    // first sample of a record fills the window: left-edge replication
    assign fill     = in_fire && (count_reg == '0);
    assign shift_in = in_fire ? in_data.sample : hist_reg[0];

    always_comb
    begin
        hist_next[0] = shift_in;
        for (int i = 1; i < WIN; i++)
        begin
            hist_next[i] = fill ? shift_in : hist_reg[i-1];
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        drain_step_next = drain_step_reg;
        drain_thr_next  = drain_thr_reg;
        calc_valid_next = calc_valid_reg;
        calc_eor_next   = calc_eor_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (in_fire)
        begin
            calc_valid_next = (count_inc == FULL_CNT);
            calc_eor_next   = 1'b0;
            if (in_data.last_sample)
            begin
                count_next      = '0;
                drain_step_next = CNT_W'(1);
                drain_thr_next  = HALF_CNT - tail_cnt;
            end
            else
            begin
                count_next = count_inc;
            end
        end
        else if (drain_fire)
        begin
            // right-edge replication; only steps whose center is a real sample emit
            calc_valid_next = (drain_step_reg > drain_thr_reg);
            calc_eor_next   = (drain_step_reg == HALF_CNT);
            drain_step_next = (drain_step_reg == HALF_CNT) ? '0
                                                           : drain_step_reg + CNT_W'(1);
        end
        else if (calc_free)
        begin
            calc_valid_next = 1'b0;
        end

        if (out_free)
        begin
            out_valid_next               = calc_valid_reg;
            out_data_next.filtered       = filtered;
            out_data_next.end_of_record  = calc_eor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            drain_step_reg <= '0;
            drain_thr_reg  <= '0;
            calc_valid_reg <= 1'b0;
            calc_eor_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            drain_step_reg <= drain_step_next;
            drain_thr_reg  <= drain_thr_next;
            calc_valid_reg <= calc_valid_next;
            calc_eor_reg   <= calc_eor_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (in_fire || drain_fire)
        begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_COUNT; i++)
            begin
                coef_reg[i] <= (i == int'(COEF_CENTER_IDX)) ? COEF_CENTER_RESET
                                                            : COEF_DIST_RESET;
            end
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    sgs_mac #(
        .MAX_HALF (MAX_HALF)
    ) u_mac (
        .hist     (hist_reg),
        .coef     (coef_reg),
        .filtered (filtered)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/sgs_checker.sv =====
// Port-level checks for the smoother, bound to the top level
`include "assert_macros.svh"

module sgs_checker
    import sgs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input sgs_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input sgs_out_t out_data
);

    // a held result keeps its value until transferred
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // the end of a record is followed by the drain, which takes no input
    `ASSERT_NEXT(a_drain_stall, clk, rst_n, in_valid && !in_stall && in_data.last_sample, in_stall)

    // no result is offered while reset is held
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind savitzky_golay_smoother sgs_checker u_sgs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
